/* sv/shs_pkg.sv */
// Package for the SHA-256 stream hasher: word types, round constants,
// initial hash values and the sigma functions. Depends on nothing.
`default_nettype none
package shs_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_hash;

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic shift_byte;
        logic expand;
    } t_msg_ctrl;

    localparam t_hash INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* sv/shs_msg.sv */
// Message schedule: a sixteen-word window that takes bytes in one at a time
// and expands one schedule word per round. Depends on shs_pkg.
`default_nettype none
module shs_msg (
    input  wire logic              i_clk,
    input  wire shs_pkg::t_msg_ctrl i_ctrl,
    input  wire logic [7:0]        i_byte,
    output shs_pkg::t_word         o_w0
);
    import shs_pkg::*;

    t_word r_w [16];
    t_word new_w;

    assign new_w = r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);
    assign o_w0  = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_byte};
        end else if (i_ctrl.expand) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= new_w;
        end
    end

endmodule
`default_nettype wire

/* sv/shs_round.sv */
// One SHA-256 compression round, shared over all 64 rounds of a block.
// Depends on shs_pkg.
`default_nettype none
module shs_round (
    input  wire shs_pkg::t_hash i_s,
    input  wire shs_pkg::t_word i_k,
    input  wire shs_pkg::t_word i_w,
    output shs_pkg::t_hash      o_s
);
    import shs_pkg::*;

    t_word t1;
    t_word t2;

    assign t1 = i_s[7] + bsig1(i_s[4]) + ((i_s[4] & i_s[5]) ^ (~i_s[4] & i_s[6]))
              + i_k + i_w;
    assign t2 = bsig0(i_s[0])
              + ((i_s[0] & i_s[1]) ^ (i_s[0] & i_s[2]) ^ (i_s[1] & i_s[2]));

    always_comb begin
        o_s[7] = i_s[6];
        o_s[6] = i_s[5];
        o_s[5] = i_s[4];
        o_s[4] = i_s[3] + t1;
        o_s[3] = i_s[2];
        o_s[2] = i_s[1];
        o_s[1] = i_s[0];
        o_s[0] = t1 + t2;
    end

endmodule
`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// SHA-256 stream hasher top level: sequencer, chaining words, bit count and
// digest output. Depends on shs_pkg, shs_msg and shs_round.
//
// The input channel carries one transaction per message byte (or an empty
// final transaction) with an end-of-message flag. The output channel carries
// eight transactions per finished message, one 32-bit digest word each, most
// significant word first, with the last one flagged.
// A byte is taken whenever the hasher is idle. When it completes a 64-byte
// block the block is compressed by one shared round unit: 64 rounds at one
// per cycle, then a fold of the result into the chaining words, during which
// the input is stalled. At the end of a message the padding bytes are shifted
// in one per cycle, except while a block is compressed, and finishing takes
// the pad bytes plus one or two compressions before the first digest word
// shows. Sustained throughput is limited by the round unit.
// While digest words are offered the input stays stalled; if the receiver
// stalls, the current word simply holds until it is taken. After the eighth
// word the hasher reloads its initial values for the next message.
// Reset returns the block to idle with the initial hash values, a zero bit
// count and an empty buffer; no clearing pass is needed.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import shs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic [63:0] r_len;
    logic        r_padding;   // message has ended, padding under way
    logic        r_pad_first; // next pad byte is the 0x80 marker
    logic        r_len_ok;    // length bytes go into this block
    logic        r_final;     // compression in flight is the last one
    t_hash       r_h;
    t_hash       r_s;
    t_hash       round_s;
    t_word       w0;
    t_msg_ctrl   msg_ctrl;
    logic        in_acc;
    logic        out_acc;
    logic        len_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  shift_in;

    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign out_acc = (r_state == ST_OUT) && !i_out_stall;

    // Padding is the marker, then zeros, then the bit count from the top byte.
    assign len_byte = r_len_ok && (r_fill >= LEN_POS);
    assign pad_byte = r_pad_first ? PAD_MARK : (len_byte ? r_len[63:56] : 8'h00);
    assign shift_in = in_acc ? i_data_byte : pad_byte;

    assign msg_ctrl.shift_byte = (in_acc && i_byte_present) || (r_state == ST_PAD);
    assign msg_ctrl.expand     = (r_state == ST_COMP);

    shs_msg u_msg (
        .i_clk  (i_clk),
        .i_ctrl (msg_ctrl),
        .i_byte (shift_in),
        .o_w0   (w0)
    );

    shs_round u_round (
        .i_s (r_s),
        .i_k (round_k(r_rnd)),
        .i_w (w0),
        .o_s (round_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_rnd       <= '0;
            r_idx       <= '0;
            r_len       <= '0;
            r_padding   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_h         <= INIT_H;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_byte_present) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd8;
                        end
                        if (i_byte_present && (r_fill == 6'd63)) begin
                            r_state     <= ST_COMP;
                            r_s         <= r_h;
                            r_rnd       <= '0;
                            r_final     <= 1'b0;
                            r_padding   <= i_end_of_message;
                            r_pad_first <= i_end_of_message;
                        end else if (i_end_of_message) begin
                            r_state     <= ST_PAD;
                            r_padding   <= 1'b1;
                            r_pad_first <= 1'b1;
                        end
                    end
                end
                ST_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                        r_len_ok    <= (r_fill < LEN_POS);
                    end else if (len_byte) begin
                        r_len <= {r_len[55:0], 8'h00};
                    end
                    if (r_fill == 6'd63) begin
                        r_state <= ST_COMP;
                        r_s     <= r_h;
                        r_rnd   <= '0;
                        r_final <= r_len_ok && !r_pad_first;
                    end
                end
                ST_COMP: begin
                    r_s   <= round_s;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_s[i];
                    end
                    if (r_final) begin
                        r_state <= ST_OUT;
                        r_idx   <= '0;
                    end else if (r_padding) begin
                        r_state  <= ST_PAD;
                        r_len_ok <= !r_pad_first;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state   <= ST_IDLE;
                            r_h       <= INIT_H;
                            r_len     <= '0;
                            r_fill    <= '0;
                            r_padding <= 1'b0;
                            r_final   <= 1'b0;
                            r_len_ok  <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

endmodule
`default_nettype wire

/* sv/shs_check.sv */
// Port-level checks for the SHA-256 stream hasher and the bind that attaches
// them. Depends on sha256_stream_hasher.
`default_nettype none
module shs_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word)
                                       && $stable(o_word_index))
        else $error("stalled digest word changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while digest is offered");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag out of step with index");

    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=>
            o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not in sequence");

endmodule

bind sha256_stream_hasher shs_check u_shs_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
`default_nettype wire

/* dv/tb_sha256_stream_hasher.sv */
// Self-checking testbench for the SHA-256 stream hasher: a byte-stream SHA-256
// predictor, a driver task per transaction and a digest checker process.
// Depends on shs_pkg (word types) and sha256_stream_hasher.
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_stream_hasher;
    import shs_pkg::*;

    // Expected digest word together with its position in the digest.
    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_exp;

    localparam int TIMEOUT_CYCLES = 20000;

    // SHA-256 round constants, kept locally so that the predictor does not
    // lean on the package's own constant function.
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: chaining words, running bit count, block buffer, fill.
    t_word       hash_state [8];
    logic [63:0] msg_bit_len;
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;

    t_digest_exp digest_queue [$];
    int          mismatch_count = 0;
    int          idle_pct = 11;      // chance in a hundred of a gap or a stall
    int          quiet_cycles = 0;   // cycles without any accepted transaction

    function automatic t_word rot_right(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Sixty-four rounds over the buffered block, folded into the chaining words.
    task automatic compress_buffer();
        t_word w [64];
        t_word a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
                 + ((e & f) ^ (~e & g)) + K_TAB[i] + w[i];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e; hash_state[5] += f;
        hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV_TAB[i];
        msg_bit_len = '0;
        block_fill = 0;
    endtask

    // Absorbs one accepted transaction; on an end mark it pads, finishes the
    // digest and queues its eight words.
    task automatic absorb_transaction(logic [7:0] data, logic present, logic fin);
        t_digest_exp exp_word;
        if (present) begin
            block_bytes[block_fill] = data;
            block_fill++;
            msg_bit_len += 64'd8;
            if (block_fill == 64) begin
                compress_buffer();
                block_fill = 0;
            end
        end
        if (fin) begin
            block_bytes[block_fill] = 8'h80;
            block_fill++;
            // No room for the length: close this block and open another.
            if (block_fill > 56) begin
                while (block_fill < 64)
                    block_bytes[block_fill++] = 8'h00;
                compress_buffer();
                block_fill = 0;
            end
            while (block_fill < 56)
                block_bytes[block_fill++] = 8'h00;
            for (int i = 0; i < 8; i++)
                block_bytes[63-i] = msg_bit_len[8*i +: 8];
            compress_buffer();
            for (int i = 0; i < 8; i++) begin
                exp_word.word  = hash_state[i];
                exp_word.index = 3'(i);
                exp_word.last  = (i == 7);
                digest_queue.push_back(exp_word);
            end
            restart_message();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drives one transaction and holds it until the block takes it. Valid and
    // payload are set at a rising edge and kept steady whilst stalled. Valid
    // is left high on return; the next call drives it anew, the drain task lowers it.
    task automatic send_byte(logic [7:0] data, logic present, logic fin);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= fin;
        do
            @(posedge i_clk);
        while (o_in_stall);
        absorb_transaction(data, present, fin);
    endtask

    task automatic send_message(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom), 1'b1, i == len - 1);
        if (len == 0)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_for_digests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // The empty message, single-byte messages of 0x00 and 0xff, then random
    // messages whose lengths straddle the one- and two-block padding boundary.
    task automatic test_padding_edges();
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_message(55);
        send_message(56);
        send_message(64);
        // An ignored byte in the middle of a message, then an empty final item.
        send_byte(8'h5a, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b0);
        send_byte(8'h3c, 1'b0, 1'b1);
    endtask

    // The sender holds off until the whole digest is out, then carries on.
    task automatic test_drain_pause();
        send_message(3);
        wait_for_digests();
        send_message(0);
    endtask

    // Mostly short well-formed messages with random content and lengths, a
    // few across block boundaries and stray non-byte items for noise.
    task automatic test_random_messages();
        int unsigned sent = 0;
        int unsigned len;
        while (sent < 270) begin
            if (sent > 80 && sent < 180)
                idle_pct = 0;
            else
                idle_pct = 11;
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom), 1'b0, 1'b0);
                sent++;
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(130, 50)
                                               : $urandom_range(12);
                send_message(len);
                sent += (len == 0) ? 1 : len;
            end
        end
        send_message(1);
        idle_pct = 11;
    endtask

    // Receiver: random stalls, with the same quiet stretch as the sender.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < idle_pct);

    // Digest checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_exp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, 32'h0);
            end else begin
                want = digest_queue.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index)
                    report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                if (o_last_word !== want.last)
                    report_mismatch("last_word", 32'(o_last_word), 32'(want.last));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= TIMEOUT_CYCLES) begin
            $display("tb_sha256_stream_hasher: FAIL");
            $finish;
        end
    end

    initial begin
        restart_message();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_padding_edges();
        test_drain_pause();
        test_random_messages();
        wait_for_digests();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_sha256_stream_hasher: PASS");
        else
            $display("tb_sha256_stream_hasher: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/shs_pkg.sv
sv/shs_msg.sv
sv/shs_round.sv
sv/sha256_stream_hasher.sv
sv/shs_check.sv
dv/tb_sha256_stream_hasher.sv
